@@ src/bctu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bctu_pkg;

    // Size of the register file seen by the exchange forms
    localparam int          REG_COUNT  = 16;
    localparam int          REG_CMP_W  = 9;
    localparam logic [REG_CMP_W-1:0] REG_LIMIT = REG_CMP_W'(REG_COUNT);

    // Status flag bit positions
    localparam int FLAG_Z = 0;
    localparam int FLAG_N = 1;
    localparam int FLAG_V = 2;
    localparam int FLAG_B = 3;
    localparam int FLAG_C = 4;
    localparam int FLAG_O = 5;

    // Branch variants, low three opcode bits (bit 3 selects the link forms)
    localparam logic [2:0] OPV_JR_ALWAYS = 3'd0;
    localparam logic [2:0] OPV_JR_FLAG   = 3'd1;
    localparam logic [2:0] OPV_JR_OPND   = 3'd2;
    localparam logic [2:0] OPV_JA_REG    = 3'd3;
    localparam logic [2:0] OPV_JA_IMM    = 3'd4;
    localparam logic [2:0] OPV_JA_FLAG   = 3'd5;
    localparam logic [2:0] OPV_JA_OPND   = 3'd6;
    localparam logic [2:0] OPV_XCHG_REG  = 3'd7;
    localparam int         OP_LINK_BIT   = 3;

    // Flag condition codes
    localparam logic [3:0] FC_Z         = 4'h0;
    localparam logic [3:0] FC_NZ        = 4'h1;
    localparam logic [3:0] FC_VEQN_NZ   = 4'h2;
    localparam logic [3:0] FC_VNEN_NZ   = 4'h3;
    localparam logic [3:0] FC_VEQN_OR_Z = 4'h4;
    localparam logic [3:0] FC_VNEN_OR_Z = 4'h5;
    localparam logic [3:0] FC_NB_NZ     = 4'h6;
    localparam logic [3:0] FC_B_NZ      = 4'h7;
    localparam logic [3:0] FC_NB_OR_Z   = 4'h8;
    localparam logic [3:0] FC_B_OR_Z    = 4'h9;
    localparam logic [3:0] FC_C         = 4'hA;
    localparam logic [3:0] FC_NC        = 4'hB;
    localparam logic [3:0] FC_N         = 4'hC;
    localparam logic [3:0] FC_O         = 4'hD;
    localparam logic [3:0] FC_V         = 4'hE;
    localparam logic [3:0] FC_NV        = 4'hF;

    // Operand condition codes
    localparam logic [3:0] OC_EQZ      = 4'h0;
    localparam logic [3:0] OC_NEZ      = 4'h1;
    localparam logic [3:0] OC_GTZ      = 4'h2;
    localparam logic [3:0] OC_LTZ      = 4'h3;
    localparam logic [3:0] OC_GEZ      = 4'h4;
    localparam logic [3:0] OC_LEZ      = 4'h5;
    localparam logic [3:0] OC_NEZ_ALT  = 4'h6;
    localparam logic [3:0] OC_NEVER    = 4'h7;
    localparam logic [3:0] OC_ALWAYS   = 4'h8;
    localparam logic [3:0] OC_EQZ_ALT  = 4'h9;
    localparam logic [3:0] OC_NZ_EQ_C  = 4'hA;
    localparam logic [3:0] OC_NZ_NE_C  = 4'hB;
    localparam logic [3:0] OC_NZ_EQ_N  = 4'hC;
    localparam logic [3:0] OC_NZ_EQ_O  = 4'hD;
    localparam logic [3:0] OC_NZ_EQ_V  = 4'hE;
    localparam logic [3:0] OC_NZ_NE_V  = 4'hF;

    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  cond;
        logic [5:0]  status_flags;
        logic [31:0] reg_value;
        logic [3:0]  reg_index;
        logic [31:0] immediate;
        logic [31:0] pc_now;
    } bctu_in_t;

    typedef struct packed {
        logic        taken;
        logic [31:0] next_pc;
        logic        push_valid;
        logic [31:0] push_value;
        logic        write_valid;
        logic [3:0]  write_index;
        logic [31:0] write_value;
    } bctu_out_t;

    // Both condition results, handed from the evaluator to the datapath
    typedef struct packed {
        logic flag_ok;
        logic opnd_ok;
    } bctu_cond_t;

endpackage

`default_nettype wire

@@ src/branch_condition_and_target_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Payload      Direction
// -------   --------------------------   ----------   ---------
// input     s_valid, s_ready, s_data     bctu_in_t    in
// result    m_valid, m_ready, m_data     bctu_out_t   out
//
// Two register stages: an input register, then condition test, target add and
// select, then the result register. The input register loads the result register,
// which holds the result until it is taken; one transfer per cycle is sustained
// while m_ready stays high.
// A stalled result holds in the result register; the input register still
// fills while it is empty or while the result register is empty or being taken.
// Reset (aresetn low, synchronous) empties both stages.

module branch_condition_and_target_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bctu_pkg::bctu_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bctu_pkg::bctu_out_t      m_data
);
    import bctu_pkg::*;

    logic       in_vld_reg;
    bctu_in_t   in_reg;
    logic       out_vld_reg;
    bctu_out_t  out_reg;
    bctu_out_t  out_next;
    logic       adv_in;
    logic       adv_out;

    bctu_cond_t  cond_res;
    logic [31:0] rel_off;
    logic [31:0] rel_tgt;
    logic [31:0] tgt;
    logic        taken;
    logic        exch;

    // Pipeline flow control
    assign adv_out = !out_vld_reg || m_ready;
    assign adv_in  = !in_vld_reg || adv_out;
    assign s_ready = adv_in;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv_in) begin
            in_vld_reg <= s_valid;
        end
        if (adv_in && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Condition tests
    bctu_cond_eval u_cond (
        .cond         (in_reg.cond),
        .status_flags (in_reg.status_flags),
        .reg_value    (in_reg.reg_value),
        .result       (cond_res)
    );

    // Relative target: sign-extended low immediate half, wraps at 2^32
    assign rel_off = {{16{in_reg.immediate[15]}}, in_reg.immediate[15:0]};
    assign rel_tgt = in_reg.pc_now + rel_off;

    // Variant decode: target source and taken decision
    always_comb begin
        exch = 1'b0;
        case (in_reg.op[2:0])
            OPV_JR_ALWAYS: begin
                tgt   = rel_tgt;
                taken = 1'b1;
            end
            OPV_JR_FLAG: begin
                tgt   = rel_tgt;
                taken = cond_res.flag_ok;
            end
            OPV_JR_OPND: begin
                tgt   = rel_tgt;
                taken = cond_res.opnd_ok;
            end
            OPV_JA_IMM: begin
                tgt   = in_reg.immediate;
                taken = 1'b1;
            end
            OPV_JA_FLAG: begin
                tgt   = in_reg.immediate;
                taken = cond_res.flag_ok;
            end
            OPV_JA_OPND: begin
                tgt   = in_reg.immediate;
                taken = cond_res.opnd_ok;
            end
            OPV_JA_REG: begin
                tgt   = in_reg.reg_value;
                taken = 1'b1;
            end
            default: begin
                tgt   = in_reg.reg_value;
                taken = 1'b1;
                exch  = 1'b1;
            end
        endcase
    end

    // Result assembly
    always_comb begin
        out_next.taken       = taken;
        out_next.next_pc     = taken ? tgt : in_reg.pc_now;
        out_next.push_valid  = taken && in_reg.op[OP_LINK_BIT];
        out_next.push_value  = in_reg.pc_now;
        out_next.write_valid = exch && ({5'd0, in_reg.reg_index} < REG_LIMIT);
        out_next.write_index = in_reg.reg_index;
        out_next.write_value = in_reg.pc_now;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv_out) begin
            out_vld_reg <= in_vld_reg;
        end
        if (adv_out && in_vld_reg) begin
            out_reg <= out_next;
        end
    end

    // Checks
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && adv_out |=> m_valid)
        else $error("input stage item lost");

    a_not_taken_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.taken |-> m_data.next_pc == m_data.push_value)
        else $error("not-taken branch changed pc");

    a_push_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.push_valid |-> m_data.taken)
        else $error("link push without taken branch");

    a_write_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_valid |-> m_data.taken
            && m_data.write_value == m_data.push_value)
        else $error("exchange write inconsistent");

endmodule

`default_nettype wire

@@ src/bctu_cond_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bctu_cond_eval (
    input  wire logic [3:0]          cond,
    input  wire logic [5:0]          status_flags,
    input  wire logic [31:0]         reg_value,
    output bctu_pkg::bctu_cond_t     result
);
    import bctu_pkg::*;

    logic z, n, v, b, c, o;
    logic nz, neg;

    assign z   = status_flags[FLAG_Z];
    assign n   = status_flags[FLAG_N];
    assign v   = status_flags[FLAG_V];
    assign b   = status_flags[FLAG_B];
    assign c   = status_flags[FLAG_C];
    assign o   = status_flags[FLAG_O];
    assign nz  = |reg_value;
    assign neg = reg_value[31];

    always_comb begin
        // Flag tests
        unique case (cond)
            FC_Z:         result.flag_ok = z;
            FC_NZ:        result.flag_ok = !z;
            FC_VEQN_NZ:   result.flag_ok = (v == n) && !z;
            FC_VNEN_NZ:   result.flag_ok = (v != n) && !z;
            FC_VEQN_OR_Z: result.flag_ok = (v == n) || z;
            FC_VNEN_OR_Z: result.flag_ok = (v != n) || z;
            FC_NB_NZ:     result.flag_ok = !b && !z;
            FC_B_NZ:      result.flag_ok = b && !z;
            FC_NB_OR_Z:   result.flag_ok = !b || z;
            FC_B_OR_Z:    result.flag_ok = b || z;
            FC_C:         result.flag_ok = c;
            FC_NC:        result.flag_ok = !c;
            FC_N:         result.flag_ok = n;
            FC_O:         result.flag_ok = o;
            FC_V:         result.flag_ok = v;
            default:      result.flag_ok = !v;
        endcase

        // Operand against zero; the unsigned below-zero test is never true
        unique case (cond)
            OC_EQZ:     result.opnd_ok = !nz;
            OC_NEZ:     result.opnd_ok = nz;
            OC_GTZ:     result.opnd_ok = !neg && nz;
            OC_LTZ:     result.opnd_ok = neg;
            OC_GEZ:     result.opnd_ok = !neg;
            OC_LEZ:     result.opnd_ok = neg || !nz;
            OC_NEZ_ALT: result.opnd_ok = nz;
            OC_NEVER:   result.opnd_ok = 1'b0;
            OC_ALWAYS:  result.opnd_ok = 1'b1;
            OC_EQZ_ALT: result.opnd_ok = !nz;
            OC_NZ_EQ_C: result.opnd_ok = (nz == c);
            OC_NZ_NE_C: result.opnd_ok = (nz != c);
            OC_NZ_EQ_N: result.opnd_ok = (nz == n);
            OC_NZ_EQ_O: result.opnd_ok = (nz == o);
            OC_NZ_EQ_V: result.opnd_ok = (nz == v);
            default:    result.opnd_ok = (nz != v);
        endcase
    end

endmodule

`default_nettype wire

@@ test/tb_branch_condition_and_target_unit.sv @@
`timescale 1ns / 1ps

module tb_branch_condition_and_target_unit;
    import bctu_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    bctu_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    bctu_out_t m_data;

    // Outcomes predicted at input transfer, oldest first
    bctu_out_t   outcomes_due[$];
    int unsigned mismatch_count;
    int unsigned send_burst_left;
    int unsigned sink_burst_left;

    branch_condition_and_target_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random wait before the next transfer, with occasional back-to-back runs
    function automatic int unsigned pick_wait(inout int unsigned burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(20, 60);
        end
        return $urandom_range(0, 19);
    endfunction

    // Branch decision, target and link/write-back for one instruction
    function automatic bctu_out_t resolve_branch(bctu_in_t b);
        bctu_out_t   r;
        logic        z, n, v, bw, c, o;
        logic        nz, neg;
        logic        flag_ok, opnd_ok, taken;
        logic [31:0] rel_target, target;
        z   = b.status_flags[FLAG_Z];
        n   = b.status_flags[FLAG_N];
        v   = b.status_flags[FLAG_V];
        bw  = b.status_flags[FLAG_B];
        c   = b.status_flags[FLAG_C];
        o   = b.status_flags[FLAG_O];
        nz  = (b.reg_value != 32'd0);
        neg = b.reg_value[31];

        // flag tests
        case (b.cond)
            FC_Z:         flag_ok = z;
            FC_NZ:        flag_ok = !z;
            FC_VEQN_NZ:   flag_ok = (v == n) && !z;
            FC_VNEN_NZ:   flag_ok = (v != n) && !z;
            FC_VEQN_OR_Z: flag_ok = (v == n) || z;
            FC_VNEN_OR_Z: flag_ok = (v != n) || z;
            FC_NB_NZ:     flag_ok = !bw && !z;
            FC_B_NZ:      flag_ok = bw && !z;
            FC_NB_OR_Z:   flag_ok = !bw || z;
            FC_B_OR_Z:    flag_ok = bw || z;
            FC_C:         flag_ok = c;
            FC_NC:        flag_ok = !c;
            FC_N:         flag_ok = n;
            FC_O:         flag_ok = o;
            FC_V:         flag_ok = v;
            default:      flag_ok = !v;
        endcase

        // operand-versus-zero tests; unsigned below zero never holds
        case (b.cond)
            OC_EQZ:     opnd_ok = !nz;
            OC_NEZ:     opnd_ok = nz;
            OC_GTZ:     opnd_ok = !neg && nz;
            OC_LTZ:     opnd_ok = neg;
            OC_GEZ:     opnd_ok = !neg;
            OC_LEZ:     opnd_ok = neg || !nz;
            OC_NEZ_ALT: opnd_ok = nz;
            OC_NEVER:   opnd_ok = 1'b0;
            OC_ALWAYS:  opnd_ok = 1'b1;
            OC_EQZ_ALT: opnd_ok = !nz;
            OC_NZ_EQ_C: opnd_ok = (nz == c);
            OC_NZ_NE_C: opnd_ok = (nz != c);
            OC_NZ_EQ_N: opnd_ok = (nz == n);
            OC_NZ_EQ_O: opnd_ok = (nz == o);
            OC_NZ_EQ_V: opnd_ok = (nz == v);
            default:    opnd_ok = (nz != v);
        endcase

        rel_target = b.pc_now + {{16{b.immediate[15]}}, b.immediate[15:0]};

        case (b.op[2:0])
            OPV_JR_ALWAYS: begin taken = 1'b1;    target = rel_target;  end
            OPV_JR_FLAG:   begin taken = flag_ok; target = rel_target;  end
            OPV_JR_OPND:   begin taken = opnd_ok; target = rel_target;  end
            OPV_JA_REG:    begin taken = 1'b1;    target = b.reg_value; end
            OPV_JA_IMM:    begin taken = 1'b1;    target = b.immediate; end
            OPV_JA_FLAG:   begin taken = flag_ok; target = b.immediate; end
            OPV_JA_OPND:   begin taken = opnd_ok; target = b.immediate; end
            default:       begin taken = 1'b1;    target = b.reg_value; end
        endcase

        r.taken       = taken;
        r.next_pc     = taken ? target : b.pc_now;
        r.push_valid  = taken && b.op[OP_LINK_BIT];
        r.push_value  = b.pc_now;
        // register read happens before write-back, so the jump target is the old value
        r.write_valid = (b.op[2:0] == OPV_XCHG_REG) && (int'(b.reg_index) < REG_COUNT);
        r.write_index = b.reg_index;
        r.write_value = b.pc_now;
        return r;
    endfunction

    function automatic bctu_in_t branch_item(logic link, logic [2:0] variant, logic [3:0] cond,
                                             logic [5:0] flags, logic [31:0] rv,
                                             logic [3:0] ri, logic [31:0] imm,
                                             logic [31:0] pc);
        bctu_in_t b;
        b.op           = {link, variant};
        b.cond         = cond;
        b.status_flags = flags;
        b.reg_value    = rv;
        b.reg_index    = ri;
        b.immediate    = imm;
        b.pc_now       = pc;
        return b;
    endfunction

    // One input transfer after a random gap; valid stays up when the gap is zero
    task automatic send_branch(bctu_in_t b);
        int unsigned gap;
        gap = pick_wait(send_burst_left);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        outcomes_due.push_back(resolve_branch(b));
    endtask

    // Hold the input side idle until every predicted outcome has come back
    task automatic drain_outcomes();
        s_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random stall after each transfer
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                hold = pick_wait(sink_burst_left);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        bctu_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                $display("%0t ns: result with none expected, actual %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = outcomes_due.pop_front();
                check_field("taken", 32'(want.taken), 32'(m_data.taken));
                check_field("next_pc", want.next_pc, m_data.next_pc);
                check_field("push_valid", 32'(want.push_valid), 32'(m_data.push_valid));
                check_field("push_value", want.push_value, m_data.push_value);
                check_field("write_valid", 32'(want.write_valid), 32'(m_data.write_valid));
                check_field("write_index", 32'(want.write_index), 32'(m_data.write_index));
                check_field("write_value", want.write_value, m_data.write_value);
            end
        end
    end

    // Always-taken forms, relative wrap at both ends, exchange on extreme registers
    task automatic test_unconditional_forms();
        send_branch(branch_item(1'b0, OPV_JR_ALWAYS, 4'h0, 6'h00, 32'h0, 4'h0,
                                32'h0000_8000, 32'h0000_0000));
        send_branch(branch_item(1'b1, OPV_JR_ALWAYS, 4'hF, 6'h3F, 32'hFFFF_FFFF, 4'hF,
                                32'hFFFF_7FFF, 32'hFFFF_FFFF));
        send_branch(branch_item(1'b0, OPV_JA_REG, 4'h5, 6'h15, 32'hFFFF_FFFF, 4'h3,
                                32'h1234_5678, 32'h8000_0000));
        send_branch(branch_item(1'b1, OPV_JA_REG, 4'hA, 6'h2A, 32'h0000_0000, 4'hC,
                                32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_branch(branch_item(1'b0, OPV_JA_IMM, 4'h0, 6'h00, 32'h0, 4'h0,
                                32'hFFFF_FFFF, 32'h0000_1000));
        send_branch(branch_item(1'b1, OPV_JA_IMM, 4'hF, 6'h3F, 32'h5555_5555, 4'hF,
                                32'h0000_0000, 32'hFFFF_FFFC));
        // exchange: target is the register value read before write-back
        send_branch(branch_item(1'b0, OPV_XCHG_REG, 4'h0, 6'h00, 32'hDEAD_BEEF, 4'hF,
                                32'h0, 32'hDEAD_BEEF));
        send_branch(branch_item(1'b1, OPV_XCHG_REG, 4'h7, 6'h3F, 32'h0000_0004, 4'h0,
                                32'hFFFF_FFFF, 32'hAAAA_AAAA));
    endtask

    // Flag tests taken and not taken, with and without link
    task automatic test_flag_conditions();
        send_branch(branch_item(1'b0, OPV_JR_FLAG, FC_Z, 6'h00, 32'h0, 4'h1,
                                32'h0000_7FFF, 32'h0000_0100));
        send_branch(branch_item(1'b1, OPV_JR_FLAG, FC_Z, 6'h3F, 32'h0, 4'h2,
                                32'h0000_7FFF, 32'hFFFF_FFF0));
        send_branch(branch_item(1'b0, OPV_JA_FLAG, FC_NV, 6'h3F, 32'h1, 4'h4,
                                32'h4000_0000, 32'h0000_0040));
        send_branch(branch_item(1'b1, OPV_JA_FLAG, FC_O, 6'h20, 32'h1, 4'h8,
                                32'hC000_0000, 32'h0000_0080));
        send_branch(branch_item(1'b1, OPV_JA_FLAG, FC_VNEN_NZ, 6'h04, 32'h0, 4'h9,
                                32'h0101_0101, 32'h2000_0000));
    endtask

    // Operand tests, including the never-true and always-true unsigned ones
    task automatic test_operand_conditions();
        send_branch(branch_item(1'b0, OPV_JR_OPND, OC_NEVER, 6'h3F, 32'h0, 4'h5,
                                32'h0000_0010, 32'h0000_2000));
        send_branch(branch_item(1'b1, OPV_JR_OPND, OC_ALWAYS, 6'h00, 32'hFFFF_FFFF, 4'h6,
                                32'h0000_FFFF, 32'h0000_0000));
        send_branch(branch_item(1'b0, OPV_JA_OPND, OC_LTZ, 6'h00, 32'h8000_0000, 4'h7,
                                32'h0BAD_F00D, 32'h0000_3000));
        send_branch(branch_item(1'b1, OPV_JA_OPND, OC_GTZ, 6'h00, 32'h8000_0000, 4'hA,
                                32'h0BAD_F00D, 32'h0000_4000));
        send_branch(branch_item(1'b0, OPV_JR_OPND, OC_LEZ, 6'h00, 32'h0, 4'hB,
                                32'h0000_8001, 32'h0001_0000));
        send_branch(branch_item(1'b1, OPV_JA_OPND, OC_NZ_NE_V, 6'h00, 32'h7FFF_FFFF, 4'hD,
                                32'hFFFF_0000, 32'h0000_5000));
    endtask

    // Random instructions; operands lean toward zero and sign boundaries
    task automatic test_random_mix(int unsigned count);
        bctu_in_t b;
        for (int unsigned i = 0; i < count; i++) begin
            b.op           = 4'($urandom_range(0, 15));
            b.cond         = 4'($urandom_range(0, 15));
            b.status_flags = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 7))
                0:       b.reg_value = 32'h0000_0000;
                1:       b.reg_value = 32'h8000_0000;
                2:       b.reg_value = 32'h7FFF_FFFF;
                3:       b.reg_value = 32'hFFFF_FFFF;
                4:       b.reg_value = 32'h0000_0001;
                default: b.reg_value = $urandom;
            endcase
            b.reg_index = 4'($urandom_range(0, 15));
            b.immediate = $urandom;
            b.pc_now    = $urandom;
            send_branch(b);
            // let the pipeline empty once in the middle
            if (i == count / 2) begin
                drain_outcomes();
            end
        end
    endtask

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        m_ready         = 1'b0;
        mismatch_count  = 0;
        send_burst_left = 0;
        sink_burst_left = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unconditional_forms();
        test_flag_conditions();
        test_operand_conditions();
        test_random_mix(2000);

        drain_outcomes();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("branch_condition_and_target_unit regression: pass");
        end else begin
            $display("branch_condition_and_target_unit regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("%0t ns: timeout, %0d outcomes outstanding", $time, outcomes_due.size());
        $display("branch_condition_and_target_unit regression: fail");
        $finish;
    end

endmodule
